// File: design/ltun_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltun_pkg
// Shared types, constants and calendar helpers for the local time to UTC
// normalizer.
// ----------------------------------------------------------------------------
package ltun_pkg;

  // Field types
  typedef logic [13:0]        year_t;
  typedef logic [3:0]         month_t;
  typedef logic [4:0]         day_t;
  typedef logic [4:0]         hour_t;
  typedef logic [5:0]         minute_t;
  typedef logic [5:0]         second_t;
  typedef logic signed [11:0] zone_t;

  // Calendar constants
  localparam int unsigned EPOCH_YEAR   = 1970;
  localparam int unsigned SEC_MIN      = 60;
  localparam int unsigned SEC_HOUR     = 60 * 60;
  localparam int unsigned SEC_DAY      = 24 * SEC_HOUR;
  localparam int unsigned DAYS_YEAR    = 365;
  localparam int unsigned DAYS_LEAP    = 366;
  localparam zone_t       ZONE_UNSPEC  = 12'sd2047;

  localparam month_t MONTH_JAN = 4'd1;
  localparam month_t MONTH_FEB = 4'd2;
  localparam month_t MONTH_MAR = 4'd3;
  localparam month_t MONTH_APR = 4'd4;
  localparam month_t MONTH_MAY = 4'd5;
  localparam month_t MONTH_JUN = 4'd6;
  localparam month_t MONTH_JUL = 4'd7;
  localparam month_t MONTH_AUG = 4'd8;
  localparam month_t MONTH_SEP = 4'd9;
  localparam month_t MONTH_OCT = 4'd10;
  localparam month_t MONTH_NOV = 4'd11;
  localparam month_t MONTH_DEC = 4'd12;

  // Reciprocal of 25, exact floor quotient for any 15 bit year
  localparam int unsigned DIV25_RECIP = 41944;
  localparam int unsigned DIV25_SHIFT = 20;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INLEAP,
    ST_MADD,
    ST_SEC,
    ST_YEAR,
    ST_YLEAP,
    ST_BLEAP,
    ST_BADD,
    ST_MONTH,
    ST_HOUR,
    ST_MIN,
    ST_DONE
  } state_t;

  // Gregorian leap rule: divisible by 4, centuries only when divisible by 400.
  // Divisible by 100 is div4 and div25; by 400 is div16 and div25.
  function automatic logic leap_of(input logic [14:0] y);
    logic [30:0] prod;
    logic [10:0] q;
    logic [14:0] q25;
    logic        div25;
    prod  = 31'(y) * 31'(DIV25_RECIP);
    q     = 11'(prod >> DIV25_SHIFT);
    q25   = {q, 4'b0000} + 15'({q, 3'b000}) + 15'(q);
    div25 = (q25 == y);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // Days of the year before the first of the given month
  function automatic logic [8:0] month_start(input logic leap, input month_t mon);
    logic [8:0] base;
    logic       add;
    add = 1'b0;
    unique case (mon)
      MONTH_JAN: base = 9'd0;
      MONTH_FEB: base = 9'd31;
      MONTH_MAR: begin base = 9'd59;  add = leap; end
      MONTH_APR: begin base = 9'd90;  add = leap; end
      MONTH_MAY: begin base = 9'd120; add = leap; end
      MONTH_JUN: begin base = 9'd151; add = leap; end
      MONTH_JUL: begin base = 9'd181; add = leap; end
      MONTH_AUG: begin base = 9'd212; add = leap; end
      MONTH_SEP: begin base = 9'd243; add = leap; end
      MONTH_OCT: begin base = 9'd273; add = leap; end
      MONTH_NOV: begin base = 9'd304; add = leap; end
      MONTH_DEC: begin base = 9'd334; add = leap; end
      default:   base = 9'd0;
    endcase
    return base + 9'(add);
  endfunction

endpackage

// File: design/ltun_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltun_in_if
// Input channel: one local calendar timestamp per transaction.
// ----------------------------------------------------------------------------
interface ltun_in_if;
  logic                valid;
  logic                ready;
  ltun_pkg::year_t     in_year;
  ltun_pkg::month_t    in_month;
  ltun_pkg::day_t      in_day;
  ltun_pkg::hour_t     in_hour;
  ltun_pkg::minute_t   in_minute;
  ltun_pkg::second_t   in_second;
  ltun_pkg::zone_t     zone_minutes;

  modport source (
    output valid, in_year, in_month, in_day, in_hour, in_minute, in_second,
           zone_minutes,
    input  ready
  );

  modport sink (
    input  valid, in_year, in_month, in_day, in_hour, in_minute, in_second,
           zone_minutes,
    output ready
  );
endinterface

// File: design/ltun_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltun_out_if
// Result channel: one normalized UTC timestamp per transaction.
// ----------------------------------------------------------------------------
interface ltun_out_if;
  logic                valid;
  logic                ready;
  ltun_pkg::year_t     out_year;
  ltun_pkg::month_t    out_month;
  ltun_pkg::day_t      out_day;
  ltun_pkg::hour_t     out_hour;
  ltun_pkg::minute_t   out_minute;
  ltun_pkg::second_t   out_second;
  logic                before_epoch;

  modport source (
    output valid, out_year, out_month, out_day, out_hour, out_minute, out_second,
           before_epoch,
    input  ready
  );

  modport sink (
    input  valid, out_year, out_month, out_day, out_hour, out_minute, out_second,
           before_epoch,
    output ready
  );
endinterface

// File: design/local_time_to_utc_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_time_to_utc_normalizer_top
// Converts a local calendar timestamp with zone offset into normalized UTC
// calendar fields, clamping instants before the epoch.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    year, month, day, hour, minute, second, zone
// out_ch   out  valid/ready    year, month, day, hour, minute, second, flag
//
// Each transaction runs through the subtract loops on the shared adder: month
// steps, hour steps and minute steps, plus day and year carry steps.
// in_ch.ready is high only while idle; the result register holds until out_ch
// accepts it. Reset is synchronous, active low, and returns the sequencer to
// idle.
//
module local_time_to_utc_normalizer_top #(
  parameter int unsigned EPOCH_YEAR = ltun_pkg::EPOCH_YEAR
) (
  input  logic        clk,
  input  logic        rst_n,
  ltun_in_if.sink     in_ch,
  ltun_out_if.source  out_ch
);

  localparam logic [14:0] EPOCH_Y = 15'(EPOCH_YEAR);

  ltun_pkg::state_t   state_r, state_nxt;
  logic [14:0]        year_r, year_nxt;
  ltun_pkg::month_t   mon_r, mon_nxt;
  logic signed [9:0]  day_r, day_nxt;
  logic signed [18:0] sec_r, sec_nxt;
  ltun_pkg::hour_t    hour_r, hour_nxt;
  ltun_pkg::minute_t  min_r, min_nxt;
  logic               leap_r, leap_nxt;
  logic               flag_r, flag_nxt;

  // Shared adder
  logic signed [19:0] alu_a, alu_b, alu_sum;
  logic               alu_neg;

  // Input decode
  logic               in_accept;
  logic [16:0]        hr_sec;
  logic [11:0]        mn_sec;
  logic signed [17:0] zn_sec;
  logic [18:0]        sec_init;
  ltun_pkg::month_t   mon_in;
  logic [9:0]         day_in;
  logic [19:0]        year_days;
  logic [19:0]        mon_days;

  assign in_accept = in_ch.valid && in_ch.ready;

  // Seconds of day before normalizing, may be negative or beyond one day
  always_comb begin
    hr_sec   = 17'(in_ch.in_hour) * 17'(ltun_pkg::SEC_HOUR);
    mn_sec   = 12'(in_ch.in_minute) * 12'(ltun_pkg::SEC_MIN);
    zn_sec   = 18'(in_ch.zone_minutes) * 18'sd60;
    sec_init = 19'(hr_sec) + 19'(mn_sec) + 19'(in_ch.in_second);
    if (in_ch.zone_minutes != ltun_pkg::ZONE_UNSPEC) begin
      sec_init = sec_init + 19'(zn_sec);
    end
    mon_in = (in_ch.in_month > ltun_pkg::MONTH_DEC) ? ltun_pkg::MONTH_DEC : in_ch.in_month;
    day_in = (in_ch.in_day == 5'd0) ? 10'd0 : 10'(in_ch.in_day - 5'd1);
  end

  assign year_days = leap_r ? 20'(ltun_pkg::DAYS_LEAP) : 20'(ltun_pkg::DAYS_YEAR);
  assign mon_days  = 20'(ltun_pkg::month_start(leap_r, mon_r));

  assign alu_sum = alu_a + alu_b;
  assign alu_neg = alu_sum[19];

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ltun_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    day_r  <= day_nxt;
    sec_r  <= sec_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    leap_r <= leap_nxt;
    flag_r <= flag_nxt;
  end

  // Sequencer: next state and shared adder operands
  always_comb begin
    state_nxt = state_r;
    year_nxt  = year_r;
    mon_nxt   = mon_r;
    day_nxt   = day_r;
    sec_nxt   = sec_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    leap_nxt  = leap_r;
    flag_nxt  = flag_r;
    alu_a     = 20'(day_r);
    alu_b     = '0;

    unique case (state_r)
      ltun_pkg::ST_IDLE: begin
        // Load the transaction
        if (in_accept) begin
          year_nxt  = 15'(in_ch.in_year);
          mon_nxt   = mon_in;
          day_nxt   = day_in;
          sec_nxt   = sec_init;
          hour_nxt  = '0;
          min_nxt   = '0;
          flag_nxt  = 1'b0;
          state_nxt = ltun_pkg::ST_INLEAP;
        end
      end
      ltun_pkg::ST_INLEAP: begin
        // Leap bit of the local year picks the month table; start at the epoch floor
        leap_nxt  = ltun_pkg::leap_of(year_r);
        year_nxt  = (year_r > EPOCH_Y) ? year_r : EPOCH_Y;
        state_nxt = ltun_pkg::ST_MADD;
      end
      ltun_pkg::ST_MADD: begin
        // Add the days of the months before, refresh leap for the base year
        alu_a     = 20'(day_r);
        alu_b     = mon_days;
        day_nxt   = alu_sum[9:0];
        leap_nxt  = ltun_pkg::leap_of(year_r);
        state_nxt = ltun_pkg::ST_SEC;
      end
      ltun_pkg::ST_SEC: begin
        // Bring seconds into one day, carrying whole days
        alu_a = 20'(sec_r);
        if (sec_r[18]) begin
          alu_b   = 20'(ltun_pkg::SEC_DAY);
          sec_nxt = alu_sum[18:0];
          day_nxt = day_r - 10'sd1;
        end else begin
          alu_b = -20'(ltun_pkg::SEC_DAY);
          if (!alu_neg) begin
            sec_nxt = alu_sum[18:0];
            day_nxt = day_r + 10'sd1;
          end else begin
            state_nxt = ltun_pkg::ST_YEAR;
          end
        end
      end
      ltun_pkg::ST_YEAR: begin
        // Bring the day count into the current year
        alu_a = 20'(day_r);
        alu_b = -year_days;
        if (day_r[9]) begin
          if (year_r == EPOCH_Y) begin
            // Before the epoch: clamp
            flag_nxt  = 1'b1;
            day_nxt   = '0;
            sec_nxt   = '0;
            mon_nxt   = ltun_pkg::MONTH_DEC;
            state_nxt = ltun_pkg::ST_MONTH;
          end else begin
            year_nxt  = year_r - 15'd1;
            state_nxt = ltun_pkg::ST_BLEAP;
          end
        end else if (!alu_neg) begin
          day_nxt   = alu_sum[9:0];
          year_nxt  = year_r + 15'd1;
          state_nxt = ltun_pkg::ST_YLEAP;
        end else begin
          mon_nxt   = ltun_pkg::MONTH_DEC;
          state_nxt = ltun_pkg::ST_MONTH;
        end
      end
      ltun_pkg::ST_YLEAP: begin
        leap_nxt  = ltun_pkg::leap_of(year_r);
        state_nxt = ltun_pkg::ST_YEAR;
      end
      ltun_pkg::ST_BLEAP: begin
        leap_nxt  = ltun_pkg::leap_of(year_r);
        state_nxt = ltun_pkg::ST_BADD;
      end
      ltun_pkg::ST_BADD: begin
        // Borrow the days of the previous year
        alu_a     = 20'(day_r);
        alu_b     = year_days;
        day_nxt   = alu_sum[9:0];
        state_nxt = ltun_pkg::ST_YEAR;
      end
      ltun_pkg::ST_MONTH: begin
        // Search months downward from December
        alu_a = 20'(day_r);
        alu_b = -mon_days;
        if (!alu_neg) begin
          day_nxt   = alu_sum[9:0];
          state_nxt = ltun_pkg::ST_HOUR;
        end else if (mon_r == ltun_pkg::MONTH_FEB) begin
          mon_nxt   = ltun_pkg::MONTH_JAN;
          state_nxt = ltun_pkg::ST_HOUR;
        end else begin
          mon_nxt = mon_r - 4'd1;
        end
      end
      ltun_pkg::ST_HOUR: begin
        alu_a = 20'(sec_r);
        alu_b = -20'(ltun_pkg::SEC_HOUR);
        if (!alu_neg) begin
          sec_nxt  = alu_sum[18:0];
          hour_nxt = hour_r + 5'd1;
        end else begin
          state_nxt = ltun_pkg::ST_MIN;
        end
      end
      ltun_pkg::ST_MIN: begin
        alu_a = 20'(sec_r);
        alu_b = -20'(ltun_pkg::SEC_MIN);
        if (!alu_neg) begin
          sec_nxt = alu_sum[18:0];
          min_nxt = min_r + 6'd1;
        end else begin
          state_nxt = ltun_pkg::ST_DONE;
        end
      end
      ltun_pkg::ST_DONE: begin
        // Hold the result until taken
        if (out_ch.ready) begin
          state_nxt = ltun_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ltun_pkg::ST_IDLE;
      end
    endcase
  end

  // Channel outputs
  assign in_ch.ready         = (state_r == ltun_pkg::ST_IDLE);
  assign out_ch.valid        = (state_r == ltun_pkg::ST_DONE);
  assign out_ch.out_year     = year_r[13:0];
  assign out_ch.out_month    = mon_r;
  assign out_ch.out_day      = day_r[4:0] + 5'd1;
  assign out_ch.out_hour     = hour_r;
  assign out_ch.out_minute   = min_r;
  assign out_ch.out_second   = sec_r[5:0];
  assign out_ch.before_epoch = flag_r;

  // Assertions
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after an accepted transaction");

  a_sec_in_day: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ltun_pkg::ST_HOUR) |-> (!sec_r[18] && sec_r < 19'sd86400))
    else $error("seconds not normalized before hour split");

  a_clamp_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.before_epoch) |->
      (out_ch.out_year == 14'(EPOCH_YEAR) && out_ch.out_month == ltun_pkg::MONTH_JAN &&
       out_ch.out_day == 5'd1 && out_ch.out_hour == 5'd0 &&
       out_ch.out_minute == 6'd0 && out_ch.out_second == 6'd0))
    else $error("clamped result is not the epoch");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the local time to UTC normalizer. A driver feeds
// local calendar timestamps from a queue. A monitor checks every normalized
// UTC result against a calendar predictor that runs inside the bench. Both
// channel sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  // Seconds arithmetic in signed 64 bit
  localparam longint EPOCH         = longint'(ltun_pkg::EPOCH_YEAR);
  localparam longint SECS_PER_MIN  = 60;
  localparam longint SECS_PER_HOUR = 3600;
  localparam longint SECS_PER_DAY  = 86400;
  localparam int     CUM_DAYS [0:12] =
    '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  localparam int     TAIL_CYCLES  = 200;
  localparam longint LIMIT_CYCLES = 8_000_000;

  typedef struct {
    ltun_pkg::year_t   year;
    ltun_pkg::month_t  month;
    ltun_pkg::day_t    day;
    ltun_pkg::hour_t   hour;
    ltun_pkg::minute_t minute;
    ltun_pkg::second_t second;
    ltun_pkg::zone_t   zone;
  } local_stamp_t;

  typedef struct {
    ltun_pkg::year_t   year;
    ltun_pkg::month_t  month;
    ltun_pkg::day_t    day;
    ltun_pkg::hour_t   hour;
    ltun_pkg::minute_t minute;
    ltun_pkg::second_t second;
    logic              clamped;
  } utc_stamp_t;

  logic clk;
  logic rst_n;

  ltun_in_if  in_ch ();
  ltun_out_if out_ch ();

  local_time_to_utc_normalizer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  local_stamp_t pending_stamps [$];
  utc_stamp_t   expected_utc [$];
  local_stamp_t on_bus;
  utc_stamp_t   got_utc;
  utc_stamp_t   want_utc;
  int           total_items;
  int           directed_items;
  int           accept_count;
  int           results_seen;
  int           mismatch_count;
  longint       cycle_count;

  // --------------------------------------------------------------------------
  // Calendar predictor
  // --------------------------------------------------------------------------
  function automatic bit is_leap(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint leaps_through(longint n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic longint days_before_month(bit leap, longint m);
    return longint'(CUM_DAYS[m]) + ((leap && m >= 3) ? 1 : 0);
  endfunction

  function automatic utc_stamp_t normalize_local(local_stamp_t t);
    longint     yr;
    longint     mo;
    longint     dy;
    longint     secs;
    longint     dayno;
    longint     rem;
    longint     y;
    longint     m;
    bit         lp;
    utc_stamp_t r;
    yr = longint'(t.year);
    mo = longint'(t.month);
    dy = longint'(t.day);
    if (mo > 12) mo = 12;
    secs = 0;
    // whole years since the epoch
    if (yr > EPOCH) begin
      secs = (365 * (yr - EPOCH) + leaps_through(yr - 1) - leaps_through(EPOCH - 1))
             * SECS_PER_DAY;
    end
    if (t.zone != ltun_pkg::ZONE_UNSPEC) secs += longint'(t.zone) * 60;
    secs += days_before_month(is_leap(yr), mo) * SECS_PER_DAY;
    secs += ((dy > 0) ? dy - 1 : 0) * SECS_PER_DAY;
    secs += longint'(t.hour) * SECS_PER_HOUR + longint'(t.minute) * SECS_PER_MIN
            + longint'(t.second);
    // clamp anything before the epoch
    r.clamped = 1'b0;
    if (secs < 0) begin
      secs      = 0;
      r.clamped = 1'b1;
    end
    dayno = secs / SECS_PER_DAY;
    rem   = secs % SECS_PER_DAY;
    // walk forward through years, then find the month
    y = EPOCH;
    while (dayno >= (is_leap(y) ? 366 : 365)) begin
      dayno -= is_leap(y) ? 366 : 365;
      y++;
    end
    lp = is_leap(y);
    m  = 1;
    for (longint k = 12; k > 1; k--) begin
      if (dayno >= days_before_month(lp, k)) begin
        m = k;
        break;
      end
    end
    dayno -= days_before_month(lp, m);
    r.year   = ltun_pkg::year_t'(y);
    r.month  = ltun_pkg::month_t'(m);
    r.day    = ltun_pkg::day_t'(dayno + 1);
    r.hour   = ltun_pkg::hour_t'(rem / SECS_PER_HOUR);
    r.minute = ltun_pkg::minute_t'((rem % SECS_PER_HOUR) / SECS_PER_MIN);
    r.second = ltun_pkg::second_t'(rem % SECS_PER_MIN);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic local_stamp_t make_stamp(int y, int mo, int d, int h, int mi,
                                              int s, int z);
    local_stamp_t t;
    t.year   = ltun_pkg::year_t'(y);
    t.month  = ltun_pkg::month_t'(mo);
    t.day    = ltun_pkg::day_t'(d);
    t.hour   = ltun_pkg::hour_t'(h);
    t.minute = ltun_pkg::minute_t'(mi);
    t.second = ltun_pkg::second_t'(s);
    t.zone   = ltun_pkg::zone_t'(z);
    return t;
  endfunction

  // Mostly recent years with sane fields; some far years, overranges and odd zones
  function automatic local_stamp_t random_stamp();
    local_stamp_t t;
    int           pick;
    pick = $urandom_range(99);
    if (pick < 75)      t.year = ltun_pkg::year_t'(1970 + $urandom_range(130));
    else if (pick < 88) t.year = ltun_pkg::year_t'($urandom_range(16383));
    else                t.year = ltun_pkg::year_t'($urandom_range(1969));
    t.month  = ($urandom_range(9) == 0) ? ltun_pkg::month_t'($urandom_range(15))
                                        : ltun_pkg::month_t'($urandom_range(12, 1));
    t.day    = ltun_pkg::day_t'($urandom_range(31));
    t.hour   = ($urandom_range(6) == 0) ? ltun_pkg::hour_t'($urandom_range(31))
                                        : ltun_pkg::hour_t'($urandom_range(23));
    t.minute = ($urandom_range(6) == 0) ? ltun_pkg::minute_t'($urandom_range(63))
                                        : ltun_pkg::minute_t'($urandom_range(59));
    t.second = ($urandom_range(6) == 0) ? ltun_pkg::second_t'($urandom_range(63))
                                        : ltun_pkg::second_t'($urandom_range(59));
    pick = $urandom_range(99);
    if (pick < 60)      t.zone = ltun_pkg::zone_t'(int'($urandom_range(2880)) - 1440);
    else if (pick < 75) t.zone = ltun_pkg::ZONE_UNSPEC;
    else                t.zone = ltun_pkg::zone_t'($urandom_range(4095));
    return t;
  endfunction

  function automatic int sender_idle_pct(int n);
    if (n < total_items / 3)     return 26;
    if (n < 2 * total_items / 3) return 63;
    return 0;
  endfunction

  function automatic int receiver_idle_pct(int n);
    if (n < total_items / 3)     return 63;
    if (n < 2 * total_items / 3) return 26;
    return 0;
  endfunction

  function automatic bit is_drain_point(int n);
    return (n == directed_items) || (n == total_items / 3) ||
           (n == 2 * total_items / 3);
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: present queued timestamps, hold until accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_utc.push_back(normalize_local(on_bus));
        accept_count++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pending_stamps.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct(accept_count) &&
            !(is_drain_point(accept_count) && results_seen != accept_count)) begin
          on_bus = pending_stamps.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.in_year      <= on_bus.year;
          in_ch.in_month     <= on_bus.month;
          in_ch.in_day       <= on_bus.day;
          in_ch.in_hour      <= on_bus.hour;
          in_ch.in_minute    <= on_bus.minute;
          in_ch.in_second    <= on_bus.second;
          in_ch.zone_minutes <= on_bus.zone;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result transaction against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_utc.year    = out_ch.out_year;
        got_utc.month   = out_ch.out_month;
        got_utc.day     = out_ch.out_day;
        got_utc.hour    = out_ch.out_hour;
        got_utc.minute  = out_ch.out_minute;
        got_utc.second  = out_ch.out_second;
        got_utc.clamped = out_ch.before_epoch;
        if (expected_utc.size() == 0) begin
          $error("unexpected result transaction: %0d-%0d-%0d %0d:%0d:%0d",
                 got_utc.year, got_utc.month, got_utc.day,
                 got_utc.hour, got_utc.minute, got_utc.second);
          mismatch_count++;
        end else begin
          want_utc = expected_utc.pop_front();
          if (got_utc.year !== want_utc.year) begin
            $error("out_year: expected %0d, actual %0d", want_utc.year, got_utc.year);
            mismatch_count++;
          end
          if (got_utc.month !== want_utc.month) begin
            $error("out_month: expected %0d, actual %0d", want_utc.month, got_utc.month);
            mismatch_count++;
          end
          if (got_utc.day !== want_utc.day) begin
            $error("out_day: expected %0d, actual %0d", want_utc.day, got_utc.day);
            mismatch_count++;
          end
          if (got_utc.hour !== want_utc.hour) begin
            $error("out_hour: expected %0d, actual %0d", want_utc.hour, got_utc.hour);
            mismatch_count++;
          end
          if (got_utc.minute !== want_utc.minute) begin
            $error("out_minute: expected %0d, actual %0d",
                   want_utc.minute, got_utc.minute);
            mismatch_count++;
          end
          if (got_utc.second !== want_utc.second) begin
            $error("out_second: expected %0d, actual %0d",
                   want_utc.second, got_utc.second);
            mismatch_count++;
          end
          if (got_utc.clamped !== want_utc.clamped) begin
            $error("before_epoch: expected %0d, actual %0d",
                   want_utc.clamped, got_utc.clamped);
            mismatch_count++;
          end
        end
        results_seen <= results_seen + 1;
      end
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct(results_seen));
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin
    in_ch.valid        = 1'b0;
    in_ch.in_year      = '0;
    in_ch.in_month     = '0;
    in_ch.in_day       = '0;
    in_ch.in_hour      = '0;
    in_ch.in_minute    = '0;
    in_ch.in_second    = '0;
    in_ch.zone_minutes = '0;
    out_ch.ready       = 1'b0;
    accept_count       = 0;
    results_seen       = 0;
    mismatch_count     = 0;
    cycle_count        = 0;

    // Directed: epoch, clamping, leap rules, overranges, zone extremes
    pending_stamps.push_back(make_stamp(1970, 1, 1, 0, 0, 0, 0));
    pending_stamps.push_back(make_stamp(1970, 1, 1, 0, 0, 0, -1));
    pending_stamps.push_back(make_stamp(1970, 1, 2, 0, 0, 0, -2048));
    pending_stamps.push_back(make_stamp(1971, 1, 1, 0, 0, 0, -60));
    pending_stamps.push_back(make_stamp(2000, 2, 29, 12, 34, 56, 2047));
    pending_stamps.push_back(make_stamp(2000, 3, 1, 0, 0, 0, 1439));
    pending_stamps.push_back(make_stamp(1900, 3, 1, 5, 6, 7, 0));
    pending_stamps.push_back(make_stamp(2100, 2, 29, 23, 59, 59, -1440));
    pending_stamps.push_back(make_stamp(2024, 12, 31, 23, 59, 59, 1));
    pending_stamps.push_back(make_stamp(0, 3, 15, 10, 0, 0, 2047));
    pending_stamps.push_back(make_stamp(1969, 12, 31, 23, 59, 59, 0));
    pending_stamps.push_back(make_stamp(1999, 0, 10, 1, 2, 3, 0));
    pending_stamps.push_back(make_stamp(1999, 13, 10, 1, 2, 3, 0));
    pending_stamps.push_back(make_stamp(2001, 15, 31, 0, 0, 0, 0));
    pending_stamps.push_back(make_stamp(2010, 6, 0, 0, 0, 0, 0));
    pending_stamps.push_back(make_stamp(2015, 4, 31, 31, 63, 63, 2046));
    pending_stamps.push_back(make_stamp(16383, 15, 31, 31, 63, 63, 2046));
    pending_stamps.push_back(make_stamp(9999, 12, 31, 23, 59, 59, 0));
    pending_stamps.push_back(make_stamp(2020, 7, 4, 0, 0, 0, -2047));
    pending_stamps.push_back(make_stamp(1988, 11, 20, 8, 30, 15, 330));
    directed_items = pending_stamps.size();

    // Random part
    repeat (80) pending_stamps.push_back(random_stamp());
    total_items = pending_stamps.size();

    // Wait until every result has come back, then let the block settle
    while (pending_stamps.size() > 0 || results_seen < total_items) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_utc.size() != 0) begin
      $error("%0d expected results never arrived", expected_utc.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
